// File: design/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// shared constants and controller/datapath interface types for the radix
// string to int64 parser
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int RADIX_W         = 6;
	localparam int OUT_W           = 64;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

	typedef struct packed {
		logic acc_clear;
		logic acc_update;
		logic out_load;
		logic out_err;
		logic neg;
	} cmd_t;

	typedef struct packed {
		logic is_minus;
		logic digit_ok;
		logic ovf;
	} status_t;

endpackage

// File: design/rsi_datapath.sv
// ----------------------------------------------------------------------------
// rsi_datapath
// radix register, digit decode, negative accumulator with overflow check
// and result register
// ----------------------------------------------------------------------------
module rsi_datapath #(
	parameter int VALUE_WIDTH = rsi_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [rsi_pkg::RADIX_W-1:0]   cfg_data,
	input  logic [7:0]                    character,
	input  rsi_pkg::cmd_t                 cmd,
	output rsi_pkg::status_t              status,
	output logic signed [VALUE_WIDTH-1:0] out_value,
	output logic                          out_err
);

	localparam int PW = VALUE_WIDTH + rsi_pkg::RADIX_W + 1;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UZ    = 8'h5A;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LZ    = 8'h7A;
	localparam logic [7:0] TEN        = 8'd10;

	localparam logic signed [VALUE_WIDTH-1:0] MIN_W = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic [rsi_pkg::RADIX_W-1:0] radix_q;
	logic signed [VALUE_WIDTH-1:0] acc_q;
	logic signed [VALUE_WIDTH-1:0] acc_new;
	logic signed [VALUE_WIDTH-1:0] res_val;
	logic signed [VALUE_WIDTH-1:0] out_value_q;
	logic out_err_q;
	logic [rsi_pkg::RADIX_W-1:0] digit;
	logic is_digit;
	logic radix_ok;
	logic signed [PW-1:0] acc_ext;
	logic signed [PW-1:0] rad_ext;
	logic signed [PW-1:0] dig_ext;
	logic signed [PW-1:0] lim_ext;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rsi_pkg::RADIX_RESET;
		end else if (cfg_valid) begin
			radix_q <= cfg_data;
		end
	end

	// digit decode
	always_comb begin
		is_digit = 1'b1;
		digit    = '0;
		if (character >= CHAR_ZERO && character <= CHAR_NINE) begin
			digit = 6'(character - CHAR_ZERO);
		end else if (character >= CHAR_UA && character <= CHAR_UZ) begin
			digit = 6'(character - CHAR_UA + TEN);
		end else if (character >= CHAR_LA && character <= CHAR_LZ) begin
			digit = 6'(character - CHAR_LA + TEN);
		end else begin
			is_digit = 1'b0;
		end
	end

	assign radix_ok = (radix_q >= rsi_pkg::RADIX_MIN) && (radix_q <= rsi_pkg::RADIX_MAX);

	// acc * radix - digit, exact in the wider width, against the limit
	assign acc_ext = PW'(acc_q);
	assign rad_ext = PW'($signed({1'b0, radix_q}));
	assign dig_ext = PW'($signed({1'b0, digit}));
	assign lim_ext = cmd.neg ? PW'(MIN_W) : PW'(MIN_W) + PW'(1);
	assign prod    = acc_ext * rad_ext;
	assign diff    = prod - dig_ext;

	assign status.is_minus = (character == CHAR_MINUS);
	assign status.digit_ok = is_digit && radix_ok && (digit < radix_q);
	assign status.ovf      = (diff < lim_ext);

	assign acc_new = cmd.acc_update ? diff[VALUE_WIDTH-1:0] : acc_q;
	assign res_val = cmd.out_err ? '0 : (cmd.neg ? acc_new : -acc_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (cmd.acc_update) begin
			acc_q <= acc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_value_q <= '0;
			out_err_q   <= 1'b0;
		end else if (cmd.out_load) begin
			out_value_q <= res_val;
			out_err_q   <= cmd.out_err;
		end
	end

	assign out_value = out_value_q;
	assign out_err   = out_err_q;

	// the accumulator never goes positive
	a_acc_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= 0)
		else $error("accumulator went positive");

	// an error result carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.out_load) && out_err |-> out_value == 0)
		else $error("error result with nonzero value");

	// the accumulator starts from zero after a string ends
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_clear |=> acc_q == 0)
		else $error("accumulator not cleared after last character");

endmodule

// File: design/rsi_ctrl.sv
// ----------------------------------------------------------------------------
// rsi_ctrl
// per-string state machine: sign, digits, sticky failure, result handshake
// ----------------------------------------------------------------------------
module rsi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tlast,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  rsi_pkg::status_t status,
	output rsi_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_START,
		ST_SIGN,
		ST_DIGIT,
		ST_FAIL
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   neg_q;
	logic   neg_nx;
	logic   m_tvalid_q;
	logic   s_fire;

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_nx       = state_q;
		neg_nx         = neg_q;
		cmd.acc_update = 1'b0;
		if (state_q == ST_START && status.is_minus) begin
			state_nx = ST_SIGN;
			neg_nx   = 1'b1;
		end else if (state_q == ST_FAIL) begin
			state_nx = ST_FAIL;
		end else if (!status.digit_ok || status.ovf) begin
			state_nx = ST_FAIL;
		end else begin
			state_nx       = ST_DIGIT;
			cmd.acc_update = s_fire;
		end
		cmd.neg       = neg_q;
		cmd.out_err   = (state_nx != ST_DIGIT);
		cmd.out_load  = s_fire && s_tlast;
		cmd.acc_clear = s_fire && s_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_START;
			neg_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				if (s_tlast) begin
					state_q <= ST_START;
					neg_q   <= 1'b0;
				end else begin
					state_q <= state_nx;
					neg_q   <= neg_nx;
				end
			end
			if (s_fire && s_tlast) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	a_last_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_tlast |=> m_tvalid)
		else $error("no result beat after last character");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_tlast |=> state_q == ST_START && !neg_q)
		else $error("string state not cleared after last character");

	a_neg_not_start: assert property (@(posedge clk) disable iff (!arst_n)
		neg_q |-> state_q != ST_START)
		else $error("minus flag set at start of string");

endmodule

// File: design/radix_string_to_int64_parser.sv
// ----------------------------------------------------------------------------
// radix_string_to_int64_parser
// signed integer text parser, one character per beat, configurable radix
// ----------------------------------------------------------------------------
// latency: the result beat is valid in the cycle after the last character
// throughput: one character per cycle; each character is one multiply-subtract
// and compare on the accumulator, and s_tready drops only while a result waits
// reset: arst_n clears the string state and sets the radix to 10
// ----------------------------------------------------------------------------
module radix_string_to_int64_parser #(
	parameter int VALUE_WIDTH = rsi_pkg::VALUE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rsi_pkg::RADIX_W-1:0]     cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // character
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [rsi_pkg::OUT_W-1:0]       m_tdata,   // value
	output logic                            m_tuser    // error
);

	rsi_pkg::cmd_t    cmd;
	rsi_pkg::status_t status;
	logic signed [VALUE_WIDTH-1:0] out_value;
	logic out_err;

	assign cfg_ready = 1'b1;

	rsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rsi_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.character (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_value (out_value),
		.out_err   (out_err)
	);

	assign m_tdata = rsi_pkg::OUT_W'(out_value);
	assign m_tuser = out_err;

endmodule

// File: tb/tb_radix_string_to_int64_parser.sv
// ----------------------------------------------------------------------------
// tb_radix_string_to_int64_parser
// self-checking bench for the radix string to int64 parser: a short table of
// hand-picked strings (sign handling, bad characters, radix limits, a radix
// change mid-string) followed by random strings in a series of radix settings,
// with boundary values around the signed 64-bit limits; each result is checked
// against its table entry or an in-bench model of the negative accumulation
// ----------------------------------------------------------------------------
module tb_radix_string_to_int64_parser;

	localparam int SETTLE = 4;
	localparam int STALL_LIMIT = 4000;
	localparam int ITEM_TARGET = 1000;
	localparam int NOT_DIGIT = 99;
	localparam longint VMAX = 64'sh7fff_ffff_ffff_ffff;

	typedef struct {
		logic [rsi_pkg::OUT_W-1:0] value;
		logic error;
	} parse_result_t;

	typedef struct {
		bit known;
		parse_result_t res;
	} typed_t;

	typedef struct {
		int pre_radix;
		int mid_radix;
		string text;
		logic [7:0] raw;
		bit known;
		longint value;
		bit err;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rsi_pkg::RADIX_W-1:0] cfg_data = rsi_pkg::RADIX_RESET;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;   // character
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [rsi_pkg::OUT_W-1:0] m_tdata;  // value
	logic m_tuser;              // error

	// model state
	logic [rsi_pkg::RADIX_W-1:0] radix_now = rsi_pkg::RADIX_RESET;
	longint acc = 0;
	bit acc_neg = 1'b0;
	bit first_char = 1'b1;
	bit digit_taken = 1'b0;
	bit string_failed = 1'b0;

	parse_result_t parsed_values[$];
	typed_t typed_values[$];
	row_t directed [15];

	int mismatches = 0;
	int items_sent = 0;
	int strings_sent = 0;
	int radix_writes = 0;
	int err_results = 0;
	int clean_results = 0;
	int stall_cycles = 0;
	int burst_left = 0;
	int rx_mode = 0;
	int rx_left = 0;

	radix_string_to_int64_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int digit_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - "0";
		if (c >= "A" && c <= "Z") return int'(c) - "A" + 10;
		if (c >= "a" && c <= "z") return int'(c) - "a" + 10;
		return NOT_DIGIT;
	endfunction

	function automatic logic [7:0] digit_char(int d);
		if (d < 10) return 8'("0" + d);
		return 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
	endfunction

	// one character into the model; done is set on the last character
	task automatic parse_char(input logic [7:0] c, input bit l, output bit done,
			output parse_result_t r);
		longint limit, multmin, rr;
		int d;
		done = 1'b0;
		r.value = '0;
		r.error = 1'b0;
		if (!string_failed) begin
			if (first_char && c == "-") begin
				acc_neg = 1'b1;
				first_char = 1'b0;
			end else begin
				first_char = 1'b0;
				d = digit_of(c);
				rr = longint'(radix_now);
				if (radix_now < rsi_pkg::RADIX_MIN || radix_now > rsi_pkg::RADIX_MAX ||
						d >= rr) begin
					string_failed = 1'b1;
				end else begin
					limit = acc_neg ? -VMAX - 1 : -VMAX;
					multmin = limit / rr;
					if (acc < multmin) begin
						string_failed = 1'b1;
					end else begin
						acc = acc * rr;
						if (acc < limit + d) begin
							string_failed = 1'b1;
						end else begin
							acc = acc - d;
							digit_taken = 1'b1;
						end
					end
				end
			end
		end
		if (l) begin
			done = 1'b1;
			r.error = string_failed || !digit_taken;
			r.value = r.error ? '0 : (acc_neg ? acc : -acc);
			acc = 0;
			acc_neg = 1'b0;
			first_char = 1'b1;
			digit_taken = 1'b0;
			string_failed = 1'b0;
		end
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("mismatch in %s: got %h, want %h", what, got, want);
	endtask

	// receiver: ready pattern switches between always, coin flip and mostly stalled
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(10, 150);
		end
		rx_left--;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		parse_result_t r;
		typed_t t;
		bit done;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				if (parsed_values.size() == 0) begin
					report_mismatch("unexpected result beat", m_tdata, '0);
				end else begin
					r = parsed_values.pop_front();
					if (m_tdata !== r.value) report_mismatch("value", m_tdata, r.value);
					if (m_tuser !== r.error)
						report_mismatch("error flag", 64'(m_tuser), 64'(r.error));
					if (r.error) err_results++;
					else clean_results++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				radix_now = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				parse_char(s_tdata, s_tlast, done, r);
				if (done) begin
					if (typed_values.size() != 0) begin
						t = typed_values.pop_front();
						if (t.known) r = t.res;
					end
					parsed_values.push_back(r);
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// sender: bursts of random length with random gaps
	task automatic push_char(input logic [7:0] c, input bit l);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (parsed_values.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_radix(input logic [rsi_pkg::RADIX_W-1:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		radix_writes++;
	endtask

	initial begin
		logic [7:0] text[$];
		typed_t typed;
		logic [rsi_pkg::RADIX_W-1:0] rdx;
		logic [63:0] mag;
		int phase, kind, len, pos, nd;
		bit want_neg, r_ok;

		directed = '{
			'{-1, -1, "0",    8'h00, 1'b1,  0, 1'b0},  // radix 10 after reset
			'{-1, -1, "-",    8'h00, 1'b1,  0, 1'b1},  // lone minus
			'{-1, -1, "-7",   8'h00, 1'b1, -7, 1'b0},
			'{-1, -1, "+5",   8'h00, 1'b1,  0, 1'b1},  // plus is not allowed
			'{-1, -1, "4-",   8'h00, 1'b1,  0, 1'b1},  // minus not in front
			'{-1, -1, "",     8'h00, 1'b1,  0, 1'b1},
			'{-1, -1, "",     8'hff, 1'b1,  0, 1'b1},
			'{36, -1, "zZ",   8'h00, 1'b1, 1295, 1'b0},
			'{ 2, -1, "12",   8'h00, 1'b1,  0, 1'b1},  // digit not below radix
			'{-1, -1, "-101", 8'h00, 1'b1, -5, 1'b0},
			'{16,  8, "17",   8'h00, 1'b0,  0, 1'b0},  // radix change mid-string
			'{ 0, -1, "0",    8'h00, 1'b1,  0, 1'b1},  // radix below range
			'{37, -1, "1",    8'h00, 1'b1,  0, 1'b1},  // radix above range
			'{63, -1, "z",    8'h00, 1'b1,  0, 1'b1},
			'{10, -1, "-0",   8'h00, 1'b1,  0, 1'b0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].pre_radix >= 0)
				write_radix(rsi_pkg::RADIX_W'(directed[i].pre_radix));
			typed.known = directed[i].known;
			typed.res.value = directed[i].value;
			typed.res.error = directed[i].err;
			typed_values.push_back(typed);
			text.delete();
			if (directed[i].text.len() == 0) text.push_back(directed[i].raw);
			else for (int k = 0; k < directed[i].text.len(); k++) text.push_back(directed[i].text[k]);
			foreach (text[k]) begin
				push_char(text[k], k == text.size() - 1);
				if (k == 0 && directed[i].mid_radix >= 0)
					write_radix(rsi_pkg::RADIX_W'(directed[i].mid_radix));
			end
			strings_sent++;
		end

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0: rdx = rsi_pkg::RADIX_MIN;
				1: rdx = rsi_pkg::RADIX_MAX;
				2: rdx = 6'd63;
				3: rdx = rsi_pkg::RADIX_RESET;
				default: begin
					if ($urandom_range(0, 9) == 0)
						rdx = rsi_pkg::RADIX_W'($urandom_range(0, 1) ? $urandom_range(0, 1) :
							$urandom_range(37, 63));
					else
						rdx = rsi_pkg::RADIX_W'($urandom_range(2, 36));
				end
			endcase
			phase++;
			write_radix(rdx);
			r_ok = rdx >= rsi_pkg::RADIX_MIN && rdx <= rsi_pkg::RADIX_MAX;
			nd = r_ok ? int'(rdx) : 36;
			repeat ($urandom_range(8, 20)) begin
				kind = $urandom_range(0, 99);
				text.delete();
				if (kind < 15 && r_ok) begin
					// just around the signed 64-bit limits, so values fall on either side of overflow
					want_neg = $urandom_range(0, 1);
					mag = want_neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
					mag = mag + 64'($urandom_range(0, 4)) - 64'd2;
					while (mag != 0) begin
						text.push_front(digit_char(int'(mag % 64'(nd))));
						mag = mag / 64'(nd);
					end
					repeat ($urandom_range(0, 2)) text.push_front("0");
					if (want_neg) text.push_front("-");
				end else if (kind < 85) begin
					if ($urandom_range(0, 2) == 0) text.push_back("-");
					len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
					repeat (len) text.push_back(digit_char($urandom_range(0, nd - 1)));
					if (kind >= 60) begin
						pos = $urandom_range(0, text.size() - 1);
						case ($urandom_range(0, 2))
							0: text[pos] = 8'($urandom_range(0, 255));
							1: text[pos] = "-";
							default: text[pos] = (nd < 36) ? digit_char($urandom_range(nd, 35)) : " ";
						endcase
					end
				end else begin
					if (kind < 90) text.push_back("-");
					repeat ($urandom_range(kind < 90 ? 0 : 1, 5))
						text.push_back(8'($urandom_range(0, 255)));
				end
				foreach (text[k]) push_char(text[k], k == text.size() - 1);
				strings_sent++;
			end
		end

		wait_idle();
		$display("covered %0d strings, %0d characters, %0d radix writes", strings_sent,
			items_sent, radix_writes);
		$display("results: %0d clean values, %0d flagged as errors", clean_results, err_results);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
